>>> rtl/bprs_pkg.sv
`timescale 1ns / 1ps

package bprs_pkg;

	// Fixed field widths
	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 4;
	localparam int COUNT_W    = 16;
	localparam int OFFSET_W   = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// Most bytes one input byte can cause (pattern and replacement are at most 8)
	localparam int EMIT_MAX = 8;
	localparam int EMIT_W   = $clog2(EMIT_MAX);

	// Entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_BYTES,
		CFG_PATTERN_LENGTH,
		CFG_REPLACEMENT_BYTES,
		CFG_REPLACEMENT_LENGTH,
		CFG_RANGE_BEGIN,
		CFG_RANGE_END,
		CFG_MAX_COUNT,
		CFG_UNLIMITED
	} cfg_reg_t;

	typedef struct packed {
		logic [63:0]         pattern_bytes;
		logic [LEN_W-1:0]    pattern_length;
		logic [63:0]         replacement_bytes;
		logic [LEN_W-1:0]    replacement_length;
		logic [OFFSET_W-1:0] range_begin;
		logic [OFFSET_W-1:0] range_end;
		logic [COUNT_W-1:0]  max_count;
		logic                unlimited;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              is_last;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  out_byte;
		logic               byte_valid;
		logic               end_of_run;
		logic               end_of_stream;
		logic [COUNT_W-1:0] match_count;
		logic               status;
	} out_item_t;

	// Work for the back end: the bytes one input byte produced
	typedef struct packed {
		logic [EMIT_MAX-1:0][BYTE_W-1:0] em;
		logic [LEN_W-1:0]                n;
		logic                            last;
		logic [COUNT_W-1:0]              report;
		logic                            err;
	} qent_t;

endpackage

>>> rtl/byte_pattern_replace_stream.sv
`timescale 1ns / 1ps
// A byte's first result is registered in the queue, then in the output register.
// Throughput: one byte per cycle while the output is not stalled and each byte yields at
// most one result; a byte yielding more (match expansion, flush of held bytes) holds the output.
// A two-entry queue between classifier and output serializer absorbs these bursts.
// Reset: asynchronous, clears stream state and queue, config registers take defaults.

module byte_pattern_replace_stream #(
	parameter int MAX_PATTERN     = 8,
	parameter int MAX_REPLACEMENT = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                data_valid,
	input  bprs_pkg::in_item_t                  data,
	output logic                                data_stall,
	output logic                                result_valid,
	input  logic                                result_stall,
	output bprs_pkg::out_item_t                 result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bprs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bprs_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int LEN_W = bprs_pkg::LEN_W;

	bprs_pkg::cfg_t  cfg_q;
	bprs_pkg::qent_t push_ent, head;
	logic            push, q_full, pop, head_valid;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_bytes      <= '0;
			cfg_q.pattern_length     <= LEN_W'(1);
			cfg_q.replacement_bytes  <= '0;
			cfg_q.replacement_length <= '0;
			cfg_q.range_begin        <= '0;
			cfg_q.range_end          <= '1;
			cfg_q.max_count          <= '0;
			cfg_q.unlimited          <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (bprs_pkg::cfg_reg_t'(cfg_index))
				bprs_pkg::CFG_PATTERN_BYTES: begin
					cfg_q.pattern_bytes <= cfg_data;
				end
				bprs_pkg::CFG_PATTERN_LENGTH: begin
					cfg_q.pattern_length <= cfg_data[LEN_W-1:0];
				end
				bprs_pkg::CFG_REPLACEMENT_BYTES: begin
					cfg_q.replacement_bytes <= cfg_data;
				end
				bprs_pkg::CFG_REPLACEMENT_LENGTH: begin
					cfg_q.replacement_length <= cfg_data[LEN_W-1:0];
				end
				bprs_pkg::CFG_RANGE_BEGIN: begin
					cfg_q.range_begin <= cfg_data[bprs_pkg::OFFSET_W-1:0];
				end
				bprs_pkg::CFG_RANGE_END: begin
					cfg_q.range_end <= cfg_data[bprs_pkg::OFFSET_W-1:0];
				end
				bprs_pkg::CFG_MAX_COUNT: begin
					cfg_q.max_count <= cfg_data[bprs_pkg::COUNT_W-1:0];
				end
				bprs_pkg::CFG_UNLIMITED: begin
					cfg_q.unlimited <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Classifier: window, match test, stream state
	bprs_front #(
		.MAX_PATTERN     (MAX_PATTERN),
		.MAX_REPLACEMENT (MAX_REPLACEMENT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.data_valid (data_valid),
		.data       (data),
		.data_stall (data_stall),
		.push       (push),
		.push_ent   (push_ent),
		.q_full     (q_full)
	);

	bprs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ent   (push_ent),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// Serializer: one result per cycle while the output is not stalled
	bprs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

>>> rtl/bprs_front.sv
`timescale 1ns / 1ps

module bprs_front #(
	parameter int MAX_PATTERN     = 8,
	parameter int MAX_REPLACEMENT = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bprs_pkg::cfg_t      cfg,
	input  logic                data_valid,
	input  bprs_pkg::in_item_t  data,
	output logic                data_stall,
	output logic                push,
	output bprs_pkg::qent_t     push_ent,
	input  logic                q_full
);

	localparam int FILL_W = $clog2(MAX_PATTERN + 1);
	localparam int LEN_W  = bprs_pkg::LEN_W;
	localparam int OFF_W  = bprs_pkg::OFFSET_W;

	logic [bprs_pkg::BYTE_W-1:0]  win_q [MAX_PATTERN];
	logic [FILL_W-1:0]            fill_q;
	logic [OFF_W-1:0]             offset_q;
	logic [bprs_pkg::COUNT_W-1:0] matches_q;
	logic                         stopped_q;

	logic [bprs_pkg::BYTE_W-1:0]  w_nx [bprs_pkg::EMIT_MAX+1];
	logic [LEN_W-1:0]             plen, rlen, fill_ext, fill_inc, n;
	logic [OFF_W-1:0]             start;
	logic [bprs_pkg::COUNT_W-1:0] matches_nx;
	logic                         accept, err, allowed, pass, full, eq, in_rng, take;
	logic                         stop_nx;

	assign accept     = data_valid && !data_stall;
	assign data_stall = q_full;

	// Effective lengths
	always_comb begin
		if (cfg.pattern_length == '0)
			plen = LEN_W'(1);
		else if (cfg.pattern_length > LEN_W'(MAX_PATTERN))
			plen = LEN_W'(MAX_PATTERN);
		else
			plen = cfg.pattern_length;
		if (cfg.replacement_length > LEN_W'(MAX_REPLACEMENT))
			rlen = LEN_W'(MAX_REPLACEMENT);
		else
			rlen = cfg.replacement_length;
	end

	// Window with the new byte placed after the held bytes
	for (genvar g = 0; g < bprs_pkg::EMIT_MAX + 1; g++) begin : g_wnx
		if (g < MAX_PATTERN) begin : g_live
			assign w_nx[g] = (fill_q == FILL_W'(g)) ? data.data_byte : win_q[g];
		end else begin : g_pad
			assign w_nx[g] = '0;
		end
	end

	// Classify the byte: pass through, still filling, match or miss
	always_comb begin
		err      = cfg.range_begin > cfg.range_end;
		allowed  = cfg.unlimited || (matches_q < cfg.max_count);
		fill_ext = LEN_W'(fill_q);
		fill_inc = fill_ext + LEN_W'(1);
		pass     = err || stopped_q || !allowed || (fill_ext >= plen);
		full     = !pass && (fill_inc == plen);
		start    = offset_q - OFF_W'(plen - LEN_W'(1));
		in_rng   = (start >= cfg.range_begin) && (start <= cfg.range_end);

		eq = 1'b1;
		for (int i = 0; i < bprs_pkg::EMIT_MAX; i++) begin
			if ((LEN_W'(i) < plen) && (w_nx[i] != cfg.pattern_bytes[8*i +: 8]))
				eq = 1'b0;
		end
		take = full && eq && in_rng;

		matches_nx = matches_q;
		if (take && (matches_q != bprs_pkg::COUNT_SAT))
			matches_nx = matches_q + 1'b1;

		stop_nx = stopped_q;
		if (full && (start > cfg.range_end))
			stop_nx = 1'b1;
		if (take && (({1'b0, start} + (OFF_W+1)'(plen)) >= {1'b0, cfg.range_end}))
			stop_nx = 1'b1;
		if (take && !cfg.unlimited && (matches_nx >= cfg.max_count))
			stop_nx = 1'b1;

		// Number of bytes emitted for this transaction
		if (take)
			n = rlen;
		else if (pass || data.is_last)
			n = fill_inc;
		else if (full)
			n = LEN_W'(1);
		else
			n = '0;
	end

	// Queue entry
	always_comb begin
		for (int i = 0; i < bprs_pkg::EMIT_MAX; i++)
			push_ent.em[i] = take ? cfg.replacement_bytes[8*i +: 8] : w_nx[i];
		push_ent.n      = n;
		push_ent.last   = data.is_last;
		push_ent.report = matches_nx;
		push_ent.err    = err;
	end

	assign push = accept && ((n != '0) || data.is_last);

	// Held bytes; a miss drops the oldest one
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < MAX_PATTERN; i++)
				win_q[i] <= (full && !take) ? w_nx[i+1] : w_nx[i];
		end
	end

	// Stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			offset_q  <= '0;
			matches_q <= '0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			if (data.is_last) begin
				fill_q    <= '0;
				offset_q  <= '0;
				matches_q <= '0;
				stopped_q <= 1'b0;
			end else begin
				if (pass || take)
					fill_q <= '0;
				else if (full)
					fill_q <= FILL_W'(plen - LEN_W'(1));
				else
					fill_q <= FILL_W'(fill_inc);
				offset_q  <= offset_q + 1'b1;
				matches_q <= matches_nx;
				stopped_q <= stop_nx;
			end
		end
	end

`ifndef SYNTH
	// The window never holds a full pattern between transactions
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < FILL_W'(MAX_PATTERN))
		else $error("hold window overfilled");

	// The end of a stream returns the stream state to its start
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && data.is_last |=> fill_q == '0 && offset_q == '0 && matches_q == '0)
		else $error("stream state not cleared after last byte");
`endif

endmodule

>>> rtl/bprs_queue.sv
`timescale 1ns / 1ps

module bprs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bprs_pkg::qent_t  push_ent,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output bprs_pkg::qent_t  head
);

	localparam int DEPTH = bprs_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	bprs_pkg::qent_t  ent_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full       = (cnt_q == CNT_W'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = ent_q[rd_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= push_ent;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

`ifndef SYNTH
	// Front end stalls before the queue overflows, back end never pops empty
	assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && !head_valid))
		else $error("queue overflow or underflow");
`endif

endmodule

>>> rtl/bprs_back.sv
`timescale 1ns / 1ps

module bprs_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  bprs_pkg::qent_t      head,
	output logic                 pop,
	output logic                 result_valid,
	input  logic                 result_stall,
	output bprs_pkg::out_item_t  result
);

	localparam int LEN_W = bprs_pkg::LEN_W;
	localparam int IDX_W = bprs_pkg::EMIT_W;

	logic [IDX_W-1:0]    idx_q;
	logic                valid_q;
	bprs_pkg::out_item_t res_q;
	logic [LEN_W-1:0]    last_idx;
	logic                load, is_end, has_byte;

	// Index of the final result of the head entry (a bare marker counts as one)
	assign last_idx = (head.n == '0) ? '0 : head.n - LEN_W'(1);
	assign is_end   = (LEN_W'(idx_q) == last_idx);
	assign has_byte = (LEN_W'(idx_q) < head.n);
	assign load     = head_valid && (!valid_q || !result_stall);
	assign pop      = load && is_end;

	// Output register
	always_ff @(posedge clk) begin
		if (load) begin
			res_q.out_byte      <= has_byte ? head.em[idx_q] : '0;
			res_q.byte_valid    <= has_byte;
			res_q.end_of_run    <= is_end;
			res_q.end_of_stream <= is_end && head.last;
			res_q.match_count   <= head.report;
			res_q.status        <= head.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (!result_stall)
				valid_q <= 1'b0;
			if (load)
				idx_q <= is_end ? '0 : idx_q + 1'b1;
		end
	end

	assign result_valid = valid_q;
	assign result       = res_q;

`ifndef SYNTH
	// End of stream only ever closes a run
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.end_of_stream |-> result.end_of_run)
		else $error("end of stream without end of run");
`endif

endmodule
